// File: hw/rtl/range_max_segment_tree_unit_macros.svh
// ----------------------------------------------------------------------------
// Range max segment tree assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RANGE_MAX_SEGMENT_TREE_UNIT_MACROS_SVH
`define RANGE_MAX_SEGMENT_TREE_UNIT_MACROS_SVH

// Same-cycle implication.
`define RMST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("range max tree: same-cycle check failed");

// Next-cycle implication.
`define RMST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("range max tree: next-cycle check failed");

`endif

// File: hw/rtl/rmst_pkg.sv
// ----------------------------------------------------------------------------
// Range max segment tree package
// Field widths, value type, saturation limits, item kinds and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package rmst_pkg;

  localparam int VALUE_W = 31;
  localparam int POS_W   = 10;
  localparam int RANGE_W = 11;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef logic [RANGE_W-1:0]        range_t;

  localparam value_t VALUE_LIMIT = 31'sd1000000000;
  localparam value_t EMPTY_MARK  = -31'sd1000000000;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WLEAF,
    ST_WCALC,
    ST_QL,
    ST_QR
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/rmst_node_ram.sv
// ----------------------------------------------------------------------------
// Range max segment tree node memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_node_ram #(
  parameter int AW = 11
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire rmst_pkg::value_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output rmst_pkg::value_t     rdata
);
  import rmst_pkg::*;

  value_t mem [2**AW];
  value_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hw/rtl/rmst_max_unit.sv
// ----------------------------------------------------------------------------
// Range max segment tree compare unit
// Signed maximum of the accumulator and the node read from memory.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_max_unit (
  input  wire rmst_pkg::value_t a,
  input  wire rmst_pkg::value_t b,
  output rmst_pkg::value_t      y
);
  import rmst_pkg::*;

  assign y = (a > b) ? a : b;

endmodule

`default_nettype wire

// File: hw/rtl/range_max_segment_tree_unit.sv
// Flow: a write stores its leaf, then rewrites each ancestor up to the root.
// A query alternates ST_QL and ST_QR steps up to its registered result.
// One item is in flight at a time; the single node memory read port sets the pace,
// one node read per tree level on a write and up to two per level on a query.
// Reset: a clearing pass writes the empty marker to all 2*LEAVES memory words,
// one per cycle, holding in_stall high until every word is cleared.
// ----------------------------------------------------------------------------
// Range max segment tree unit
// Point-update, range-max-query tree over LEAVES signed leaf slots.
// ----------------------------------------------------------------------------
`default_nettype none

module range_max_segment_tree_unit #(
  parameter int LEAVES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_kind,
  input  wire rmst_pkg::pos_t    in_position,
  input  wire rmst_pkg::value_t  in_value,
  input  wire rmst_pkg::range_t  in_range_start,
  input  wire rmst_pkg::range_t  in_range_end,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rmst_pkg::value_t       out_max_value
);
  import rmst_pkg::*;

  `include "range_max_segment_tree_unit_macros.svh"

  // Heap is 1-based: node 1 is the root, leaf x sits at x + LEAVES.
  localparam int LEVELS = $clog2(LEAVES);
  localparam int NW     = LEVELS + 1;   // node address, 1 .. 2*LEAVES-1
  localparam int QW     = LEVELS + 2;   // query bounds reach 2*LEAVES

  localparam logic [NW-1:0] ROOT = NW'(1);

  state_t          state_r, state_nxt;
  logic [NW-1:0]   clr_r, clr_nxt;
  logic [QW-1:0]   l_r, l_nxt;        // node index on writes, left bound on queries
  logic [QW-1:0]   r_r, r_nxt;
  value_t          acc_r, acc_nxt;    // running node value or running maximum
  logic            pend_r, pend_nxt;  // memory read data is to be folded in
  logic            out_valid_r, out_valid_nxt;
  value_t          out_max_r, out_max_nxt;

  // memory port and compare unit
  logic            ram_we;
  logic [NW-1:0]   ram_waddr;
  value_t          ram_wdata;
  logic [NW-1:0]   ram_raddr;
  value_t          ram_rdata;
  value_t          mx;
  value_t          acc_fold;

  logic            in_xfer;
  logic            out_free;
  logic            q_done;
  logic            pos_ok;
  value_t          v_sat;
  logic [31:0]     a_cl, b_cl;
  logic [NW-1:0]   parent;
  logic [QW-1:0]   r_dec;

  rmst_node_ram #(.AW(NW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rmst_max_unit u_max (
    .a (acc_r),
    .b (ram_rdata),
    .y (mx)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign q_done    = (l_r >= r_r);
  assign acc_fold  = pend_r ? mx : acc_r;
  assign pos_ok    = (32'(in_position) < 32'(LEAVES));
  assign parent    = l_r[NW-1:1] == '0 ? ROOT : NW'(l_r[NW-1:1]);
  assign r_dec     = r_r - QW'(1);

  // Saturate the written value, clamp the query bounds to the leaf count.
  always_comb begin
    if (in_value > VALUE_LIMIT) begin
      v_sat = VALUE_LIMIT;
    end else if (in_value < EMPTY_MARK) begin
      v_sat = EMPTY_MARK;
    end else begin
      v_sat = in_value;
    end
    a_cl = (32'(in_range_start) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(in_range_start);
    b_cl = (32'(in_range_end) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(in_range_end);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_kind == KIND_QUERY) begin
            state_nxt = ST_QL;
          end else if (pos_ok) begin
            state_nxt = ST_WLEAF;
          end
        end
      end
      ST_WLEAF: begin
        state_nxt = ST_WCALC;
      end
      ST_WCALC: begin
        if (parent == ROOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QL: begin
        if (!q_done) begin
          state_nxt = ST_QR;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QR: begin
        state_nxt = ST_QL;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    clr_nxt       = clr_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    acc_nxt       = acc_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_max_nxt   = out_max_r;
    ram_we        = 1'b0;
    ram_waddr     = l_r[NW-1:0];
    ram_wdata     = acc_r;
    ram_raddr     = l_r[NW-1:0];
    case (state_r)
      ST_CLEAR: begin
        // sweep every word to the empty marker
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = EMPTY_MARK;
        clr_nxt   = clr_r + NW'(1);
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_kind == KIND_QUERY) begin
            acc_nxt = EMPTY_MARK;
            l_nxt   = QW'(a_cl + 32'(LEAVES));
            r_nxt   = QW'(b_cl + 32'(LEAVES));
          end else begin
            acc_nxt = v_sat;
            l_nxt   = QW'(32'(in_position) + 32'(LEAVES));
          end
        end
      end
      ST_WLEAF: begin
        // store the leaf, fetch its sibling
        ram_we    = 1'b1;
        ram_waddr = l_r[NW-1:0];
        ram_wdata = acc_r;
        ram_raddr = l_r[NW-1:0] ^ NW'(1);
      end
      ST_WCALC: begin
        // parent takes the larger child; fetch the next sibling
        ram_we    = 1'b1;
        ram_waddr = parent;
        ram_wdata = mx;
        ram_raddr = parent ^ NW'(1);
        acc_nxt   = mx;
        l_nxt     = QW'(parent);
      end
      ST_QL: begin
        acc_nxt = acc_fold;
        if (q_done) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_max_nxt   = acc_fold;
          end
        end else if (l_r[0]) begin
          // left bound is a right child: take it, step past it
          ram_raddr = l_r[NW-1:0];
          pend_nxt  = 1'b1;
          l_nxt     = l_r + QW'(1);
        end
      end
      ST_QR: begin
        acc_nxt = acc_fold;
        if (r_r[0]) begin
          // right bound is a right child: take its left neighbor
          ram_raddr = r_dec[NW-1:0];
          pend_nxt  = 1'b1;
          r_nxt     = r_dec >> 1;
        end else begin
          r_nxt     = r_r >> 1;
        end
        l_nxt = l_r >> 1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    acc_r     <= acc_nxt;
    out_max_r <= out_max_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_max_value = out_max_r;

  // In the ancestor walk the current node is never the root, so no step goes above it.
  `RMST_ASSERT_IMP(a_wcalc_below_root, state_r == ST_WCALC, l_r > QW'(1))
  // Stepping the left bound never carries it past the right bound.
  `RMST_ASSERT_IMP(a_qr_bounds, state_r == ST_QR, l_r <= r_r)
  // A new result only comes out of a finished query walk.
  `RMST_ASSERT_IMP(a_result_source, $rose(out_valid_r), $past(state_r) == ST_QL)
  // Results stay within the saturation limits.
  `RMST_ASSERT_IMP(a_result_range, out_valid_r,
                   (out_max_r <= VALUE_LIMIT) && (out_max_r >= EMPTY_MARK))

endmodule

`default_nettype wire
